@@ sv/qrm_pkg.sv @@
// Package for the quaternion to rotation matrix block.
// Widths, the divider stage record and the result saturation helper; no dependencies.
package qrm_pkg;

    localparam int FRAC_BITS = 14;
    localparam int QW        = FRAC_BITS + 1;     // quotient bits
    localparam int NW        = 33;                // norm width
    localparam int NUMW      = 34;                // signed numerator width
    localparam int DW        = NW + QW;           // dividend / remainder width
    localparam int LANES     = 9;

    // One divider stage: nine remainders sharing one shifted divisor
    typedef struct packed {
        logic [LANES-1:0][DW-1:0] rem;
        logic [DW-1:0]            dvs;
        logic [LANES-1:0][QW-1:0] quo;
        logic [LANES-1:0]         neg;
        logic                     zero;
    } div_t;

    // Apply sign and saturate to 16 bits
    function automatic logic [15:0] sat_entry(input logic [QW-1:0] q, input logic neg);
        logic [QW+16:0] qx;
        logic [QW+16:0] nx;
        logic [15:0]    r;
        qx = {17'd0, q};
        nx = 0 - qx;
        if (neg)
        begin
            if (qx > (QW+17)'(32768))
                r = 16'h8000;
            else
                r = nx[15:0];
        end
        else
        begin
            if (qx > (QW+17)'(32767))
                r = 16'h7FFF;
            else
                r = qx[15:0];
        end
        return r;
    endfunction

endpackage

@@ sv/qrm_div_stage.sv @@
// One restoring division step for all nine lanes, registered.
// Depends on qrm_pkg.
module qrm_div_stage
    import qrm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  logic in_valid,
    input  div_t in_data,
    output logic out_valid,
    output div_t out_data
);

    logic valid_reg;
    div_t data_reg;
    div_t data_next;

    // compare-subtract per lane, shift divisor down
    always_comb
    begin
        data_next = in_data;
        for (int i = 0; i < LANES; i++)
        begin
            if (in_data.rem[i] >= in_data.dvs)
            begin
                data_next.rem[i] = in_data.rem[i] - in_data.dvs;
                data_next.quo[i] = {in_data.quo[i][QW-2:0], 1'b1};
            end
            else
            begin
                data_next.quo[i] = {in_data.quo[i][QW-2:0], 1'b0};
            end
        end
        data_next.dvs = in_data.dvs >> 1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

@@ sv/quaternion_to_rotation_matrix.sv @@
// Top level: quaternion to 3x3 rotation matrix, fully pipelined.
// Depends on qrm_pkg and qrm_div_stage.
//
// channel   dir  tdata                          tuser
// s_axis    in   w,x,y,z (16 b each)            -
// m_axis    out  r00..r22 (16 b each)           zero_norm
//
// Registered stages in order: products, sums, dividend, one divider stage per
// quotient bit, output. One request per cycle is accepted while the output is
// not stalled. Reset clears the valid bits only. A stall at the output freezes
// every stage, so nothing is lost or repeated.
module quaternion_to_rotation_matrix
    import qrm_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_axis_tvalid,
    output logic           s_axis_tready,
    input  logic [63:0]    s_axis_tdata,   // quat_w, quat_x, quat_y, quat_z
    output logic           m_axis_tvalid,
    input  logic           m_axis_tready,
    output logic [143:0]   m_axis_tdata,   // r00,r01,r02,r10,r11,r12,r20,r21,r22
    output logic           m_axis_tuser    // zero_norm
);

    logic adv;
    logic v1_reg, v2_reg, v3_reg, vo_reg;
    logic [QW:0] dv;

    // stage 1: products
    logic signed [31:0] ww_reg, xx_reg, yy_reg, zz_reg;
    logic signed [31:0] xy_reg, wz_reg, xz_reg, wy_reg, yz_reg, wx_reg;
    // stage 2: norm and numerators
    logic [NW-1:0]                   n_reg;
    logic [LANES-1:0][NUMW-1:0]      num_reg;
    // stage 3 feeds the divider
    div_t d3_reg;
    div_t d3_next;
    // output
    logic [143:0] out_reg;
    logic [143:0] out_next;
    logic         zn_reg;

    assign adv           = !vo_reg || m_axis_tready;
    assign s_axis_tready = adv;

    logic signed [15:0] w, x, y, z;
    assign w = s_axis_tdata[15:0];
    assign x = s_axis_tdata[31:16];
    assign y = s_axis_tdata[47:32];
    assign z = s_axis_tdata[63:48];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ww_reg <= w * w;
            xx_reg <= x * x;
            yy_reg <= y * y;
            zz_reg <= z * z;
            xy_reg <= x * y;
            wz_reg <= w * z;
            xz_reg <= x * z;
            wy_reg <= w * y;
            yz_reg <= y * z;
            wx_reg <= w * x;
        end
    end

    // numerators, sign extended to NUMW
    logic signed [NUMW-1:0] eww, exx, eyy, ezz, exy, ewz, exz, ewy, eyz, ewx;
    assign eww = NUMW'(ww_reg);
    assign exx = NUMW'(xx_reg);
    assign eyy = NUMW'(yy_reg);
    assign ezz = NUMW'(zz_reg);
    assign exy = NUMW'(xy_reg);
    assign ewz = NUMW'(wz_reg);
    assign exz = NUMW'(xz_reg);
    assign ewy = NUMW'(wy_reg);
    assign eyz = NUMW'(yz_reg);
    assign ewx = NUMW'(wx_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            n_reg      <= NW'(ww_reg[30:0]) + NW'(xx_reg[30:0])
                        + NW'(yy_reg[30:0]) + NW'(zz_reg[30:0]);
            num_reg[0] <= eww + exx - eyy - ezz;
            num_reg[1] <= (exy - ewz) <<< 1;
            num_reg[2] <= (exz + ewy) <<< 1;
            num_reg[3] <= (exy + ewz) <<< 1;
            num_reg[4] <= eww - exx + eyy - ezz;
            num_reg[5] <= (eyz - ewx) <<< 1;
            num_reg[6] <= (exz - ewy) <<< 1;
            num_reg[7] <= (eyz + ewx) <<< 1;
            num_reg[8] <= eww - exx - eyy + ezz;
        end
    end

    // stage 3: magnitude, rounded dividend, top divisor
    always_comb
    begin
        logic [NUMW-1:0] mag;
        d3_next      = '0;
        d3_next.zero = (n_reg == '0);
        d3_next.dvs  = DW'(n_reg) << (QW-1);
        for (int i = 0; i < LANES; i++)
        begin
            d3_next.neg[i] = num_reg[i][NUMW-1];
            mag = num_reg[i][NUMW-1] ? (0 - num_reg[i]) : num_reg[i];
            d3_next.rem[i] = (DW'(mag[NW-1:0]) << FRAC_BITS) + DW'(n_reg >> 1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            d3_reg <= d3_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= s_axis_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            vo_reg <= dv[QW];
        end
    end

    // divider chain, one quotient bit per stage
    div_t        dd [QW+1];
    assign dv[0] = v3_reg;
    assign dd[0] = d3_reg;

    for (genvar s = 0; s < QW; s++)
    begin : g_div
        qrm_div_stage u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (adv),
            .in_valid (dv[s]),
            .in_data  (dd[s]),
            .out_valid(dv[s+1]),
            .out_data (dd[s+1])
        );
    end

    // sign, saturate, zero-norm gating
    always_comb
    begin
        out_next = '0;
        for (int i = 0; i < LANES; i++)
        begin
            if (!dd[QW].zero)
                out_next[i*16 +: 16] = sat_entry(dd[QW].quo[i], dd[QW].neg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg <= out_next;
            zn_reg  <= dd[QW].zero;
        end
    end

    assign m_axis_tvalid = vo_reg;
    assign m_axis_tdata  = out_reg;
    assign m_axis_tuser  = zn_reg;

endmodule

@@ sv/qrm_checker.sv @@
// Port-level checks for quaternion_to_rotation_matrix, bound to the top level.
// Depends on the top level's ports only.
module qrm_checker
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [143:0] m_axis_tdata,
    input logic         m_axis_tuser
);

    // zero quaternion result carries all-zero entries
    a_zero_entries: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("zero_norm with nonzero entries");

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // empty output register never blocks input
    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked with empty output");

    // taking a result frees the pipe in the same cycle
    a_ready_drain: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready |-> s_axis_tready)
        else $error("input blocked while result taken");

endmodule

bind quaternion_to_rotation_matrix qrm_checker u_qrm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
);
